[hdl/fq_pkg.sv]
// Shared types, constants and helper functions of the binary32 floor quantizer.
`default_nettype none
package fq_pkg;

  localparam logic [31:0] QuietBit   = 32'h0040_0000;
  localparam logic [31:0] SignBit    = 32'h8000_0000;
  localparam logic [31:0] FracMask   = 32'h007f_ffff;
  localparam logic [31:0] DefaultNan = 32'hffc0_0000;
  localparam logic [31:0] ExpInf     = 32'h7f80_0000;
  localparam logic [31:0] MinusOne   = 32'hbf80_0000;
  localparam int          ExpBias    = 127;

  // configuration register indexes
  localparam logic [0:0] RegStepSize = 1'b0;
  localparam logic [0:0] RegInvStep  = 1'b1;

  // unpacked operand pair after special-case screening
  typedef struct packed {
    logic        special;   // result fully known
    logic [31:0] spec_res;
    logic        sgn;
    logic [23:0] mx;        // normalized significand, bit 23 set
    logic [23:0] my;
    logic signed [10:0] e;  // ex + ey - bias
  } fq_unp_t;

  // significand product plus exponent
  typedef struct packed {
    logic        special;
    logic [31:0] spec_res;
    logic        sgn;
    logic [47:0] prod;
    logic signed [10:0] e;
  } fq_prd_t;

  // count leading zeros of a 24-bit significand
  function automatic logic [4:0] fq_lzc24(input logic [23:0] v);
    logic [4:0] n;
    logic       found;
    n = 5'd0;
    found = 1'b0;
    for (int i = 23; i >= 0; i--) begin
      if (!found && v[i]) begin
        found = 1'b1;
      end else if (!found) begin
        n = n + 5'd1;
      end
    end
    return n;
  endfunction

  // exact floor of a binary32 value
  function automatic logic [31:0] fq_floor(input logic [31:0] v);
    logic [31:0] m;
    logic [7:0]  be;
    logic [31:0] r;
    be = v[30:23];
    m  = '0;
    r  = v;
    if (be >= 8'd150) begin
      r = v;
    end else if (be < 8'd127) begin
      if (v[30:0] == 31'd0) r = v;
      else r = v[31] ? MinusOne : 32'd0;
    end else begin
      m = FracMask >> (be - 8'd127);
      if ((v & m) != 32'd0) begin
        if (v[31]) r = (v + m) & ~m;
        else r = v & ~m;
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[hdl/fq_mul.sv]
// Three-stage binary32 multiplier: unpack, significand product, round and pack.
`default_nettype none
module fq_mul (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire logic        valid_i,
  input  wire logic [31:0] x_i,
  input  wire logic [31:0] y_i,
  output logic             valid_o,
  output logic [31:0]      res_o
);

  fq_pkg::fq_unp_t unp_d, unp_q;
  fq_pkg::fq_prd_t prd_d, prd_q;
  logic [31:0]     res_d, res_q;
  logic [2:0]      vld_q;

  // stage 1: screen special cases, normalize subnormals
  always_comb begin
    logic [7:0]  ex, ey;
    logic [22:0] fx, fy;
    logic        zx, zy, sg;
    logic [23:0] sx, sy;
    logic [4:0]  lx, ly;
    ex = x_i[30:23];
    ey = y_i[30:23];
    fx = x_i[22:0];
    fy = y_i[22:0];
    sg = x_i[31] ^ y_i[31];
    zx = (ex == 8'd0) && (fx == 23'd0);
    zy = (ey == 8'd0) && (fy == 23'd0);
    sx = (ex != 8'd0) ? {1'b1, fx} : {1'b0, fx};
    sy = (ey != 8'd0) ? {1'b1, fy} : {1'b0, fy};
    lx = fq_pkg::fq_lzc24(sx);
    ly = fq_pkg::fq_lzc24(sy);
    unp_d = '0;
    unp_d.sgn = sg;
    unp_d.mx = sx << lx;
    unp_d.my = sy << ly;
    unp_d.e = 11'(signed'({3'b0, (ex == 8'd0) ? 8'd1 : ex}))
            + 11'(signed'({3'b0, (ey == 8'd0) ? 8'd1 : ey}))
            - 11'(signed'({6'b0, lx})) - 11'(signed'({6'b0, ly}))
            - 11'(fq_pkg::ExpBias);
    if (ex == 8'hff && fx != 23'd0) begin
      unp_d.special = 1'b1;
      unp_d.spec_res = x_i | fq_pkg::QuietBit;
    end else if (ey == 8'hff && fy != 23'd0) begin
      unp_d.special = 1'b1;
      unp_d.spec_res = y_i | fq_pkg::QuietBit;
    end else if (ex == 8'hff || ey == 8'hff) begin
      unp_d.special = 1'b1;
      unp_d.spec_res = (zx || zy) ? fq_pkg::DefaultNan : ({sg, 31'd0} | fq_pkg::ExpInf);
    end else if (zx || zy) begin
      unp_d.special = 1'b1;
      unp_d.spec_res = {sg, 31'd0};
    end
  end

  // stage 2: 24x24 significand product
  always_comb begin
    prd_d.special  = unp_q.special;
    prd_d.spec_res = unp_q.spec_res;
    prd_d.sgn      = unp_q.sgn;
    prd_d.e        = unp_q.e;
    prd_d.prod     = 48'(unp_q.mx) * 48'(unp_q.my);
  end

  // stage 3: normalize, round to nearest even, pack
  always_comb begin
    logic [47:0] p;
    logic signed [10:0] e;
    logic [5:0]  sh;
    logic [47:0] sig, rem, half;
    logic        up;
    p = prd_q.prod;
    e = prd_q.e;
    if (p[47]) e = e + 11'sd1;
    else p = p << 1;
    sh = (e > 11'sd0) ? 6'd24 : ((e < -11'sd24) ? 6'd49 : 6'(11'sd25 - e));
    sig = p >> sh;
    rem = p & ((48'd1 << sh) - 48'd1);
    half = 48'd1 << (sh - 6'd1);
    up = (rem > half) || ((rem == half) && sig[0]);
    sig = sig + 48'(up);
    if (prd_q.special) begin
      res_d = prd_q.spec_res;
    end else if (e >= 11'sd255) begin
      res_d = {prd_q.sgn, 31'd0} | fq_pkg::ExpInf;
    end else if (sh > 6'd48) begin
      res_d = {prd_q.sgn, 31'd0};
    end else if (e <= 11'sd0) begin
      res_d = {prd_q.sgn, sig[30:0]};
    end else if (sig[24]) begin
      if (e + 11'sd1 >= 11'sd255) res_d = {prd_q.sgn, 31'd0} | fq_pkg::ExpInf;
      else res_d = {prd_q.sgn, 8'(e + 11'sd1), 23'd0};
    end else begin
      res_d = {prd_q.sgn, e[7:0], sig[22:0]};
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      unp_q <= unp_d;
      prd_q <= prd_d;
      res_q <= res_d;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  assign valid_o = vld_q[2];
  assign res_o   = res_q;

endmodule
`default_nettype wire

[hdl/float32_floor_quantizer_unit.sv]
// Top level: value * inverse step, floor, times step, as a seven-stage pipeline.
//
//  channel | signals                                     | direction
//  --------+---------------------------------------------+----------
//  cfg     | cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i | in
//  in      | in_valid_i, in_stall_o, value_bits_i        | in
//  out     | out_valid_o, out_stall_i, quantized_bits_o  | out
//
// One item enters per cycle while the pipeline is not stalled.
// Reset clears all valid bits and loads 1.0 into both step registers.
// A stall on the output freezes the whole pipeline; in_stall_o follows it
// only when the output register holds a result, so a stall with nothing
// waiting at the output does not hold the pipeline.
`default_nettype none
module float32_floor_quantizer_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] value_bits_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      quantized_bits_o
);

  logic [31:0] step_q, inv_q;
  logic        en;
  logic        m1_valid, m2_valid;
  logic [31:0] m1_res, m2_res;
  logic        fl_valid_q;
  logic [31:0] fl_q;

  // pipeline advances unless a result waits on a stalled output
  assign en          = !(out_valid_o && out_stall_i);
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 32'h3f80_0000;
      inv_q  <= 32'h3f80_0000;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        fq_pkg::RegStepSize: step_q <= cfg_data_i;
        fq_pkg::RegInvStep:  inv_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  fq_mul u_mul_inv (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i),
    .x_i(value_bits_i), .y_i(inv_q), .valid_o(m1_valid), .res_o(m1_res)
  );

  // floor stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fl_valid_q <= 1'b0;
    end else if (en) begin
      fl_valid_q <= m1_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fl_q <= fq_pkg::fq_floor(m1_res);
    end
  end

  fq_mul u_mul_step (
    .clk_i, .rst_ni, .en_i(en), .valid_i(fl_valid_q),
    .x_i(fl_q), .y_i(step_q), .valid_o(m2_valid), .res_o(m2_res)
  );

  assign out_valid_o      = m2_valid;
  assign quantized_bits_o = m2_res;

endmodule
`default_nettype wire
